// ===== hdl/von_mises_equivalent_stress_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the von Mises equivalent stress block
// Each macro builds one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VON_MISES_EQUIVALENT_STRESS_TOP_ASSERT_SVH
`define VON_MISES_EQUIVALENT_STRESS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMES_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold after the antecedent, delayed by the delay argument.
`define VMES_ASSERT_DELAY(label, ante, delay, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##delay (cons)) else $error(msg);

`endif

// ===== hdl/vmes_pkg.sv =====
// ----------------------------------------------------------------------------
// von Mises equivalent stress package
// Shared widths and defaults for the equivalent stress pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vmes_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int OUT_WIDTH = 32;
	localparam int RAD_WIDTH = 2 * OUT_WIDTH;
	localparam int PRE_STAGES = 5;
	localparam int LATENCY = PRE_STAGES + OUT_WIDTH;

endpackage

`default_nettype wire

// ===== hdl/von_mises_equivalent_stress_top.sv =====
// An accepted transaction passes five stages that form the radicand (differences,
// partial products, squares, two adder stages), then a 32-stage square root
// pipeline that resolves one result bit per stage, before its done strobe.
// Throughput: one transaction per cycle; busy is always low.
// The receiver cannot stall, so results are never held back.
// Reset clears only the valid bits; the data path registers are not reset.
// ----------------------------------------------------------------------------
// von Mises equivalent stress
// Computes floor(sqrt(X)) of the exact 1.5 * dev:dev in wide integers,
// saturated at the output maximum with an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "von_mises_equivalent_stress_top_assert.svh"

module von_mises_equivalent_stress_top #(
	parameter int COMPONENT_WIDTH = vmes_pkg::COMPONENT_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_xx,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_yy,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_zz,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_yz,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_xz,
	input  wire logic signed [COMPONENT_WIDTH-1:0] stress_xy,
	output logic                                   done,
	output logic [vmes_pkg::OUT_WIDTH-1:0]         equivalent_value,
	output logic                                   overflow
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int DW = CW + 1;
	localparam int HL = (DW + 1) / 2;
	localparam int HH = DW - HL;
	localparam int SQW = 2 * DW;
	localparam int SUMW = SQW + 2;
	localparam int XW = SQW + 4;
	localparam int OW = vmes_pkg::OUT_WIDTH;
	localparam int RADW = vmes_pkg::RAD_WIDTH;
	localparam int RS = OW;
	localparam int REMW = OW + 2;
	localparam int CURW = REMW + 2;
	localparam int LATENCY = vmes_pkg::LATENCY;

	logic signed [DW-1:0] ext_c [6];
	logic signed [DW-1:0] arg_c [6];
	logic [DW-1:0]        mag_c [6];

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DW-1:0]        mag_s1 [6];
	logic [2*HL-1:0]      ll_s2 [6];
	logic [HL+HH-1:0]     lh_s2 [6];
	logic [2*HH-1:0]      hh_s2 [6];
	logic [SQW-1:0]       sq_s3 [6];
	logic [SUMW-1:0]      nsum_s4, ssum_s4;
	logic [XW-1:0]        total_c;
	logic [RADW-1:0]      rad_c;
	logic                 ovf_c;

	logic                 vld_s  [RS+1];
	logic                 ovf_s  [RS+1];
	logic [RADW-1:0]      rad_s  [RS+1];
	logic [REMW-1:0]      rem_s  [RS+1];
	logic [OW-1:0]        root_s [RS+1];

	assign busy = 1'b0;

	assign ext_c[0] = DW'(stress_xx);
	assign ext_c[1] = DW'(stress_yy);
	assign ext_c[2] = DW'(stress_zz);
	assign ext_c[3] = DW'(stress_yz);
	assign ext_c[4] = DW'(stress_xz);
	assign ext_c[5] = DW'(stress_xy);

	assign arg_c[0] = ext_c[0] - ext_c[1];
	assign arg_c[1] = ext_c[1] - ext_c[2];
	assign arg_c[2] = ext_c[2] - ext_c[0];
	assign arg_c[3] = ext_c[3];
	assign arg_c[4] = ext_c[4];
	assign arg_c[5] = ext_c[5];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			mag_c[i] = arg_c[i][DW-1] ? DW'(-arg_c[i]) : DW'(arg_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			mag_s1[i] <= mag_c[i];
			ll_s2[i] <= (2*HL)'(mag_s1[i][HL-1:0]) * (2*HL)'(mag_s1[i][HL-1:0]);
			lh_s2[i] <= (HL+HH)'(mag_s1[i][HL-1:0]) * (HL+HH)'(mag_s1[i][DW-1:HL]);
			hh_s2[i] <= (2*HH)'(mag_s1[i][DW-1:HL]) * (2*HH)'(mag_s1[i][DW-1:HL]);
			sq_s3[i] <= SQW'(ll_s2[i]) + (SQW'(lh_s2[i]) << (HL + 1))
				+ (SQW'(hh_s2[i]) << (2 * HL));
		end
		nsum_s4 <= SUMW'(sq_s3[0]) + SUMW'(sq_s3[1]) + SUMW'(sq_s3[2]);
		ssum_s4 <= SUMW'(sq_s3[3]) + SUMW'(sq_s3[4]) + SUMW'(sq_s3[5]);
		rad_s[0] <= rad_c;
		ovf_s[0] <= ovf_c;
	end

	assign total_c = XW'(nsum_s4 >> 1) + XW'(ssum_s4) + (XW'(ssum_s4) << 1);

	generate
		if (XW > RADW) begin : g_sat
			assign ovf_c = |total_c[XW-1:RADW];
			assign rad_c = total_c[RADW-1:0];
		end else begin : g_nosat
			assign ovf_c = 1'b0;
			assign rad_c = RADW'(total_c);
		end
	endgenerate

	assign rem_s[0] = '0;
	assign root_s[0] = '0;

	generate
		for (genvar k = 0; k < RS; k++) begin : g_root
			logic [CURW-1:0] cur_c;
			logic [CURW-1:0] trial_c;
			logic            fit_c;

			assign cur_c = {rem_s[k], rad_s[k][RADW-1:RADW-2]};
			assign trial_c = CURW'({root_s[k], 2'b01});
			assign fit_c = cur_c >= trial_c;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else begin
					vld_s[k+1] <= vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				rad_s[k+1] <= {rad_s[k][RADW-3:0], 2'b00};
				ovf_s[k+1] <= ovf_s[k];
				rem_s[k+1] <= fit_c ? REMW'(cur_c - trial_c) : REMW'(cur_c);
				root_s[k+1] <= {root_s[k][OW-2:0], fit_c};
			end
		end
	endgenerate

	assign done = vld_s[RS];
	assign overflow = ovf_s[RS];
	assign equivalent_value = ovf_s[RS] ? '1 : root_s[RS];

	`VMES_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done, "transaction lost in pipeline")
	`VMES_ASSERT_DELAY(a_no_phantom, !(start && !busy), LATENCY, !done, "done without a transaction")
	`VMES_ASSERT_DELAY(a_ovf_travel, vld_s[0] && ovf_s[0], RS, done && overflow, "overflow dropped")
	`VMES_ASSERT_IMPLY(a_rem_bound, done, rem_s[RS] <= REMW'({root_s[RS], 1'b0}), "root remainder too large")

endmodule

`default_nettype wire
